// File: rtl/xor_key_bundle_unmask_unit_macros.svh
// Assertion macros used by the top level of the XOR key bundle unmasking RTL.
`ifndef XOR_KEY_BUNDLE_UNMASK_UNIT_MACROS_SVH
`define XOR_KEY_BUNDLE_UNMASK_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define XKBU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
// Next-cycle implication, disabled during reset.
`define XKBU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define XKBU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define XKBU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/xkbu_pkg.sv
// Types and constants for the XOR key bundle unmasking unit.
package xkbu_pkg;

    localparam int HEAD_LEN    = 7;
    localparam int SHORT_LIMIT = 32'h20;
    localparam int TOTAL_START = 8 + 4;
    localparam int CNT_W       = $clog2(HEAD_LEN + 1);

    // Signature bytes, entry 0 first.
    localparam logic [HEAD_LEN-1:0][7:0] SIGNATURE =
        {8'h53, 8'h46, 8'h79, 8'h74, 8'h69, 8'h6E, 8'h55};

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [31:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       key_applied;
        logic       end_of_payload;
        logic       bundle_ok;
        logic       end_of_burst;
    } t_out_item;

    // Results produced by one step of the core.
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [HEAD_LEN-1:0][7:0] bytes;
        logic                      key;
        logic                      eop;
        logic                      ok;
    } t_burst;

endpackage

// File: rtl/xor_key_bundle_unmask_unit.sv
// Top level of the XOR key bundle unmasking unit: input stage, core, result buffer.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// One byte per cycle through input register, core logic and result register while
// the output is not stalled and no burst drains; bytes then stream back to back.
// The head release is a burst of 7 results from the result buffer; no byte is
// taken into the core while a burst still has more than one result to drain.
// Synchronous active-low reset clears the control state; no clearing pass.
// A stalled output holds the buffer and, once the input register is full, the input.
`include "xor_key_bundle_unmask_unit_macros.svh"

module xor_key_bundle_unmask_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  xkbu_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output xkbu_pkg::t_out_item o_out_data
);
    import xkbu_pkg::*;

    logic                     r_in_vld;
    t_in_item                 r_in;
    logic [CNT_W-1:0]         r_ob_cnt;
    logic [HEAD_LEN-1:0][7:0] r_ob_bytes;
    logic                     r_ob_key, r_ob_eop, r_ob_ok;

    t_burst burst;
    logic   ob_take, ob_free, go, load;

    assign ob_take    = o_out_valid && i_out_ready;
    assign ob_free    = (r_ob_cnt == '0) || ((r_ob_cnt == CNT_W'(1)) && i_out_ready);
    assign go         = r_in_vld && ob_free;
    assign load       = go && (burst.count != '0);
    assign o_in_ready = !r_in_vld || go;

    xkbu_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (go),
        .i_item  (r_in),
        .o_burst (burst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else if (load) begin
            r_ob_cnt <= burst.count;
        end else if (ob_take) begin
            r_ob_cnt <= r_ob_cnt - CNT_W'(1);
        end
    end

    // Load a new burst, or advance the burst one byte per taken transaction.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ob_bytes <= burst.bytes;
            r_ob_key   <= burst.key;
            r_ob_eop   <= burst.eop;
            r_ob_ok    <= burst.ok;
        end else if (ob_take) begin
            for (int i = 0; i < HEAD_LEN - 1; i++) begin
                r_ob_bytes[i] <= r_ob_bytes[i+1];
            end
        end
    end

    assign o_out_valid               = (r_ob_cnt != '0);
    assign o_out_data.out_byte       = r_ob_bytes[0];
    assign o_out_data.key_applied    = r_ob_key;
    assign o_out_data.end_of_payload = r_ob_eop;
    assign o_out_data.bundle_ok      = r_ob_ok;
    assign o_out_data.end_of_burst   = (r_ob_cnt == CNT_W'(1));

    `XKBU_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, load, o_out_valid)
    `XKBU_ASSERT_NXT(a_burst_no_gap, i_clk, i_rst_n, ob_take && !o_out_data.end_of_burst, o_out_valid)
    `XKBU_ASSERT_IMP(a_burst_mid_no_eop, i_clk, i_rst_n, o_out_valid && !o_out_data.end_of_burst, !o_out_data.end_of_payload)
    `XKBU_ASSERT_IMP(a_ok_on_decoded_end, i_clk, i_rst_n, o_out_valid && o_out_data.bundle_ok, o_out_data.end_of_payload && o_out_data.key_applied)

endmodule

// File: rtl/xkbu_core.sv
// Per-byte state machine: head capture, signature check, XOR and header parse.
module xkbu_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  xkbu_pkg::t_in_item i_item,
    output xkbu_pkg::t_burst   o_burst
);
    import xkbu_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int HW = $clog2(HEAD_LEN - 1);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PASS  = 3'd1;
    localparam logic [2:0] PH_HEAD  = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_STR1  = 3'd4;
    localparam logic [2:0] PH_STR2  = 3'd5;
    localparam logic [2:0] PH_TOTAL = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    logic [2:0]    r_phase, c_phase, n_phase;
    logic [LB-1:0] r_idx, c_idx, n_idx;
    logic [LB-1:0] r_len, c_len, n_len;
    logic [7:0]    r_key, c_key, n_key;
    logic          r_xor, c_xor, n_xor;
    logic [3:0]    r_seen, c_seen, n_seen;
    logic [63:0]   r_acc, c_acc, n_acc;
    logic [7:0]    r_head [HEAD_LEN-1];

    logic [LB-1:0] len_raw, len_eff;
    logic [7:0]    b, d, key_calc;
    logic          last, match, head_we;
    t_burst        burst;

    assign b = i_item.data_byte;

    // A first byte restarts the payload before the step is taken.
    always_comb begin
        len_raw = i_item.payload_length[LB-1:0];
        len_eff = (len_raw == '0) ? LB'(1) : len_raw;
        if (i_item.first_byte) begin
            c_phase = (len_eff < LB'(SHORT_LIMIT)) ? PH_PASS : PH_HEAD;
            c_idx   = '0;
            c_len   = len_eff;
            c_key   = '0;
            c_xor   = 1'b0;
            c_seen  = '0;
            c_acc   = '0;
        end else begin
            c_phase = r_phase;
            c_idx   = r_idx;
            c_len   = r_len;
            c_key   = r_key;
            c_xor   = r_xor;
            c_seen  = r_seen;
            c_acc   = r_acc;
        end
    end

    always_comb begin
        last     = (c_idx == c_len - LB'(1));
        key_calc = r_head[0] ^ SIGNATURE[0];
        match    = ((b ^ key_calc) == SIGNATURE[HEAD_LEN-1]);
        for (int i = 1; i < HEAD_LEN - 1; i++) begin
            if ((r_head[i] ^ key_calc) != SIGNATURE[i]) begin
                match = 1'b0;
            end
        end
        d       = c_xor ? (b ^ c_key) : b;
        n_phase = c_phase;
        n_idx   = c_idx;
        n_len   = c_len;
        n_key   = c_key;
        n_xor   = c_xor;
        n_seen  = c_seen;
        n_acc   = c_acc;
        head_we = 1'b0;
        burst   = '0;

        unique case (c_phase)
            PH_IDLE: begin
            end
            PH_PASS: begin
                burst.count    = CNT_W'(1);
                burst.bytes[0] = b;
                burst.eop      = last;
                n_idx          = c_idx + LB'(1);
                if (last) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HEAD: begin
                n_idx = c_idx + LB'(1);
                if (c_idx < LB'(HEAD_LEN - 1)) begin
                    head_we = 1'b1;
                end else begin
                    // Release the whole head, decoded if the signature holds.
                    for (int i = 0; i < HEAD_LEN - 1; i++) begin
                        burst.bytes[i] = match ? (r_head[i] ^ key_calc) : r_head[i];
                    end
                    burst.bytes[HEAD_LEN-1] = match ? (b ^ key_calc) : b;
                    burst.count = CNT_W'(HEAD_LEN);
                    burst.key   = match;
                    n_key       = key_calc;
                    n_xor       = match;
                    n_phase     = match ? PH_SKIP : PH_DONE;
                end
            end
            default: begin
                if (c_xor) begin
                    case (c_phase)
                        PH_SKIP: begin
                            if (c_idx >= LB'(TOTAL_START - 1)) begin
                                n_phase = PH_STR1;
                            end
                        end
                        PH_STR1: begin
                            if (d == 8'h00) begin
                                n_phase = PH_STR2;
                            end
                        end
                        PH_STR2: begin
                            if (d == 8'h00) begin
                                n_phase = PH_TOTAL;
                                n_seen  = '0;
                                n_acc   = '0;
                            end
                        end
                        PH_TOTAL: begin
                            n_acc  = {c_acc[55:0], d};
                            n_seen = c_seen + 4'd1;
                            if (n_seen >= 4'd8) begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                burst.count    = CNT_W'(1);
                burst.bytes[0] = d;
                burst.key      = c_xor;
                burst.eop      = last;
                burst.ok       = last && c_xor && (n_phase == PH_DONE) &&
                                 (n_acc == {{(64 - LB){1'b0}}, c_len});
                n_idx          = c_idx + LB'(1);
                if (last) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_len   <= '0;
            r_key   <= '0;
            r_xor   <= 1'b0;
            r_seen  <= '0;
            r_acc   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_key   <= n_key;
            r_xor   <= n_xor;
            r_seen  <= n_seen;
            r_acc   <= n_acc;
        end
    end

    // Head bytes are payload: overwritten before every signature check.
    always_ff @(posedge i_clk) begin
        if (i_step && head_we) begin
            r_head[c_idx[HW-1:0]] <= b;
        end
    end

endmodule

// File: tb/tb_xor_key_bundle_unmask_unit.sv
// Self-checking testbench for the XOR key bundle unmasking unit: directed table, random payloads.
module tb_xor_key_bundle_unmask_unit;
    import xkbu_pkg::*;

    localparam int LENGTH_BITS  = 32;
    localparam int GAP_MAX      = 17;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 470;
    localparam int TAIL_CYCLES  = 30;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PASS, ST_HEAD, ST_SKIP, ST_NAME1, ST_NAME2, ST_TOTAL, ST_DONE
    } t_parse_st;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_ONE} t_row_kind;

    typedef struct packed {
        t_in_item  item;
        t_row_kind kind;
        t_out_item want;
    } t_dir_row;

    localparam t_out_item NO_RES = '0;

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int bad_count = 0;
    int idle_cycles = 0;
    t_out_item unmasked_due[$];

    // Predictor state, reset values as after i_rst_n
    logic [7:0]  head_held [HEAD_LEN] = '{default: 8'h00};
    logic [7:0]  key_r     = 8'h00;
    logic [31:0] idx_r     = '0;
    logic [31:0] len_r     = '0;
    t_parse_st   phase     = ST_IDLE;
    logic        xor_on    = 1'b0;
    logic [3:0]  total_n   = '0;
    logic [63:0] total_acc = '0;

    // Directed rows: key 0x5A for the matching head, a corrupt final byte for the failing one
    t_dir_row dir_rows [25] = '{
        {{8'hAB, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'hFF, 1'b1, 32'h0000_0001}, ROW_ONE,  {8'hFF, 1'b0, 1'b1, 1'b0, 1'b1}},
        {{8'h00, 1'b1, 32'h0000_0000}, ROW_ONE,  {8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        {{8'h80, 1'b1, 32'h0000_0002}, ROW_ONE,  {8'h80, 1'b0, 1'b0, 1'b0, 1'b1}},
        {{8'h7F, 1'b0, 32'hFFFF_FFFF}, ROW_ONE,  {8'h7F, 1'b0, 1'b1, 1'b0, 1'b1}},
        {{8'h11, 1'b1, 32'h0000_001F}, ROW_ONE,  {8'h11, 1'b0, 1'b0, 1'b0, 1'b1}},
        {{8'h22, 1'b1, 32'h0000_0001}, ROW_ONE,  {8'h22, 1'b0, 1'b1, 1'b0, 1'b1}},
        {{8'h55, 1'b1, 32'h0000_0020}, ROW_NONE, NO_RES},
        {{8'h6E, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h69, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h74, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h79, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h46, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h00, 1'b0, 32'h0000_0000}, ROW_PRED, NO_RES},
        {{8'h53, 1'b0, 32'h0000_0000}, ROW_PRED, NO_RES},
        {{8'h0F, 1'b1, 32'hFFFF_FFFF}, ROW_NONE, NO_RES},
        {{8'h34, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h33, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h2E, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h23, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h1C, 1'b0, 32'h0000_0000}, ROW_NONE, NO_RES},
        {{8'h09, 1'b0, 32'h0000_0000}, ROW_PRED, NO_RES},
        {{8'h5A, 1'b0, 32'h0000_0000}, ROW_PRED, NO_RES},
        {{8'hA5, 1'b0, 32'h0000_0000}, ROW_PRED, NO_RES},
        {{8'h00, 1'b1, 32'h0000_0020}, ROW_NONE, NO_RES}
    };

    xor_key_bundle_unmask_unit #(
        .LENGTH_BITS(LENGTH_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the predictor by one accepted byte; return how many results it causes
    function automatic int unmask_step(input t_in_item it, output t_out_item res [HEAD_LEN]);
        logic [31:0] len;
        logic [31:0] idx;
        logic        last;
        logic        match;
        logic        ok;
        logic [7:0]  d;
        foreach (res[i]) res[i] = '0;
        if (it.first_byte) begin
            len = it.payload_length & LEN_MASK;
            if (len == 0) len = 1;
            len_r     = len;
            idx_r     = '0;
            xor_on    = 1'b0;
            key_r     = 8'h00;
            total_n   = '0;
            total_acc = '0;
            phase     = (len < SHORT_LIMIT) ? ST_PASS : ST_HEAD;
        end
        if (phase == ST_IDLE || len_r == 0) return 0;
        idx  = idx_r;
        last = (idx == len_r - 1);

        if (phase == ST_PASS) begin
            res[0] = '{out_byte: it.data_byte, key_applied: 1'b0, end_of_payload: last,
                       bundle_ok: 1'b0, end_of_burst: 1'b1};
            idx_r = idx + 1;
            if (last) phase = ST_IDLE;
            return 1;
        end

        if (phase == ST_HEAD) begin
            if (idx < HEAD_LEN) head_held[idx] = it.data_byte;
            idx_r = idx + 1;
            if (idx < HEAD_LEN - 1) return 0;
            key_r = head_held[0] ^ SIGNATURE[0];
            match = 1'b1;
            for (int i = 1; i < HEAD_LEN; i++)
                if ((head_held[i] ^ key_r) != SIGNATURE[i]) match = 1'b0;
            xor_on = match;
            for (int i = 0; i < HEAD_LEN; i++) begin
                res[i].out_byte     = match ? (head_held[i] ^ key_r) : head_held[i];
                res[i].key_applied  = match;
                res[i].end_of_burst = (i == HEAD_LEN - 1);
            end
            phase = match ? ST_SKIP : ST_DONE;
            return HEAD_LEN;
        end

        d = xor_on ? (it.data_byte ^ key_r) : it.data_byte;
        if (xor_on) begin
            case (phase)
                ST_SKIP: if (idx >= TOTAL_START - 1) phase = ST_NAME1;
                ST_NAME1: if (d == 8'h00) phase = ST_NAME2;
                ST_NAME2: if (d == 8'h00) begin
                    phase     = ST_TOTAL;
                    total_n   = '0;
                    total_acc = '0;
                end
                ST_TOTAL: begin
                    total_acc = {total_acc[55:0], d};
                    total_n   = total_n + 4'd1;
                    if (total_n >= 4'd8) phase = ST_DONE;
                end
                default: ;
            endcase
        end
        ok = last && xor_on && phase == ST_DONE && total_acc == {32'h0, len_r};
        res[0] = '{out_byte: d, key_applied: xor_on, end_of_payload: last,
                   bundle_ok: ok, end_of_burst: 1'b1};
        idx_r = idx + 1;
        if (last) phase = ST_IDLE;
        return 1;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic offer(input t_in_item it);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic feed(input t_in_item it);
        t_out_item res [HEAD_LEN];
        int        n;
        offer(it);
        n = unmask_step(it, res);
        for (int k = 0; k < n; k++) unmasked_due.push_back(res[k]);
    endtask

    // Receiver: random stalls per result, one long hold-off on request
    initial begin
        int unsigned wait_n;
        wait (rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                wait_n = quiet ? 0 : $urandom_range(0, GAP_MAX);
                if (wait_n > 0) begin
                    out_ready <= 1'b0;
                    repeat (wait_n) @(posedge i_clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (unmasked_due.size() == 0) begin
                $error("unexpected result: out_byte %h", out_data.out_byte);
                bad_count++;
            end else begin
                want = unmasked_due.pop_front();
                if (out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
                    bad_count++;
                end
                if (out_data.key_applied !== want.key_applied) begin
                    $error("key_applied: expected %b, got %b",
                           want.key_applied, out_data.key_applied);
                    bad_count++;
                end
                if (out_data.end_of_payload !== want.end_of_payload) begin
                    $error("end_of_payload: expected %b, got %b",
                           want.end_of_payload, out_data.end_of_payload);
                    bad_count++;
                end
                if (out_data.bundle_ok !== want.bundle_ok) begin
                    $error("bundle_ok: expected %b, got %b",
                           want.bundle_ok, out_data.bundle_ok);
                    bad_count++;
                end
                if (out_data.end_of_burst !== want.end_of_burst) begin
                    $error("end_of_burst: expected %b, got %b",
                           want.end_of_burst, out_data.end_of_burst);
                    bad_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[xor_key_bundle_unmask_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_out_item   res [HEAD_LEN];
        t_in_item    it;
        logic [7:0]  plain [$];
        logic [7:0]  key;
        logic [63:0] total;
        int unsigned sent;
        int unsigned choice;
        int unsigned pick;
        int unsigned n1;
        int unsigned n2;
        int unsigned tot_at;
        int unsigned n_eff;
        int unsigned n_send;
        logic [31:0] length;
        int          n;
        bit          left_open;
        bit          held;
        bit          paused;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            offer(dir_rows[r].item);
            n = unmask_step(dir_rows[r].item, res);
            case (dir_rows[r].kind)
                ROW_PRED: for (int k = 0; k < n; k++) unmasked_due.push_back(res[k]);
                ROW_ONE:  unmasked_due.push_back(dir_rows[r].want);
                default: ;
            endcase
        end

        // The last directed row leaves a long payload open
        left_open = 1'b1;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) quiet = ~quiet;
            if (!held && sent > 120) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && sent > 300) begin
                // drop valid and let the block drain completely
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (unmasked_due.size() != 0) @(posedge i_clk);
                paused = 1'b1;
            end

            choice = $urandom_range(0, 99);
            if (choice >= 90 && !left_open) begin
                repeat ($urandom_range(1, 3)) begin
                    it = '{data_byte: 8'($urandom), first_byte: 1'b0,
                           payload_length: $urandom};
                    feed(it);
                end
                continue;
            end

            plain.delete();
            key = 8'h00;
            if (choice >= 67 && choice < 85) begin
                // short payload, zero length counts as one byte
                length = $urandom_range(0, SHORT_LIMIT - 1);
                n_eff  = (length == 0) ? 1 : length;
                repeat (n_eff) plain.push_back(8'($urandom));
            end else begin
                key = 8'($urandom);
                n1  = $urandom_range(0, 12);
                n2  = $urandom_range(0, 6);
                for (int i = 0; i < HEAD_LEN; i++) plain.push_back(SIGNATURE[i]);
                repeat (TOTAL_START - HEAD_LEN) plain.push_back(8'($urandom));
                repeat (n1) plain.push_back(8'($urandom_range(1, 255)));
                plain.push_back(8'h00);
                repeat (n2) plain.push_back(8'($urandom_range(1, 255)));
                plain.push_back(8'h00);
                tot_at = plain.size();
                pick   = $urandom_range(0, 9);
                if (pick < 3)       length = tot_at + 8;
                else if (pick == 3) length = tot_at + $urandom_range(0, 7);
                else                length = tot_at + 8 + $urandom_range(0, 24);
                if (length < SHORT_LIMIT) length = SHORT_LIMIT;
                total = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : {32'h0, length};
                for (int i = 0; i < 8; i++) plain.push_back(total[63 - 8 * i -: 8]);
                while (plain.size() < length) plain.push_back(8'($urandom));
                if (choice >= 55 && choice < 67)
                    plain[$urandom_range(1, HEAD_LEN - 1)] ^= 8'($urandom_range(1, 255));
                if (choice >= 85) begin
                    // huge length, abandoned by the next payload
                    length = $urandom;
                    if (length < 64) length = 64;
                end
                n_eff = length;
            end

            n_send = n_eff;
            if (choice >= 85) n_send = $urandom_range(1, 40);
            else if ($urandom_range(0, 7) == 0 && n_eff > 1)
                n_send = $urandom_range(1, n_eff - 1);
            while (plain.size() < n_send) plain.push_back(8'($urandom));

            for (int pos = 0; pos < n_send; pos++) begin
                it.data_byte      = plain[pos] ^ key;
                it.first_byte     = (pos == 0);
                it.payload_length = (pos == 0) ? length : $urandom;
                feed(it);
                sent++;
            end
            left_open = (n_send < n_eff);
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (unmasked_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (bad_count == 0 && unmasked_due.size() == 0) begin
            $display("[xor_key_bundle_unmask_unit] OK");
        end else begin
            if (unmasked_due.size() != 0)
                $error("%0d expected results never arrived", unmasked_due.size());
            $display("[xor_key_bundle_unmask_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/xkbu_pkg.sv
rtl/xkbu_core.sv
rtl/xor_key_bundle_unmask_unit.sv
tb/tb_xor_key_bundle_unmask_unit.sv
